[hdl/lrbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbt_pkg
// shared widths, event codes, register indexes and control types for the
// link reconnect backoff tracker
// ----------------------------------------------------------------------------
package lrbt_pkg;

    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 63;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_START     = 3'd0;
    localparam logic [OP_W-1:0] OP_CONN_FAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_AP_JOIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_DISCONN   = 3'd3;
    localparam logic [OP_W-1:0] OP_GOT_ADDR  = 3'd4;
    localparam logic [OP_W-1:0] OP_LOST_ADDR = 3'd5;
    localparam logic [OP_W-1:0] OP_TIMEOUT   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 1'd1;

    localparam logic [DATA_W-1:0] BASE_DELAY_RST = 32'd1000;
    localparam logic [DATA_W-1:0] MAX_DELAY_RST  = 32'd30000;

    localparam int MAX_SHIFT_DEF = 16;

    // restoring remainder, one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic accept;
        logic clamp;
        logic step;
        logic sum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sched;
    } sts_t;

endpackage

[hdl/lrbt_evt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbt_evt_if
// link event channel: valid/ready with event payload
// ----------------------------------------------------------------------------
interface lrbt_evt_if;
    logic                            valid;
    logic                            ready;
    logic [lrbt_pkg::OP_W-1:0]       op;
    logic                            connect_ok;
    logic [lrbt_pkg::DATA_W-1:0]     random_value;
    logic [lrbt_pkg::TIME_W-1:0]     now_us;

    modport source (output valid, output op, output connect_ok,
                    output random_value, output now_us, input ready);
    modport sink   (input valid, input op, input connect_ok,
                    input random_value, input now_us, output ready);
endinterface

[hdl/lrbt_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbt_rsp_if
// result channel: valid/ready with timer request and link status payload
// ----------------------------------------------------------------------------
interface lrbt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            stop_timer;
    logic                            arm_timer;
    logic [lrbt_pkg::DATA_W-1:0]     retry_delay;
    logic                            link_up;
    logic                            has_address;
    logic                            degraded;
    logic [lrbt_pkg::DATA_W-1:0]     retries;
    logic [lrbt_pkg::DATA_W-1:0]     disconnects;
    logic [lrbt_pkg::TIME_W-1:0]     last_grant_us;

    modport source (output valid, output stop_timer, output arm_timer,
                    output retry_delay, output link_up, output has_address,
                    output degraded, output retries, output disconnects,
                    output last_grant_us, input ready);
    modport sink   (input valid, input stop_timer, input arm_timer,
                    input retry_delay, input link_up, input has_address,
                    input degraded, input retries, input disconnects,
                    input last_grant_us, output ready);
endinterface

[hdl/link_reconnect_backoff_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_tracker
// link status tracking with capped exponential reconnect backoff and jitter
//
//   port    dir   kind            contents
//   evt     in    valid/ready     op, connect_ok, random_value, now_us
//   rsp     out   valid/ready     timer request, delay, flags, counters, time
//   cfg_*   in    write enable    0 base_delay_ms, 1 max_delay_ms
//
// events without a reconnect: result loaded in S_DONE after the transfer, once the result slot is free
// reconnect events: result loaded after S_CLAMP, the 32-step jitter remainder in
// S_DIV and the jitter sum in S_SUM, then in S_DONE once the result slot is free
// one event in flight at a time; the next event is taken while a result waits
// reset restores base 1000 ms, max 30000 ms and clears all status
// ----------------------------------------------------------------------------
module link_reconnect_backoff_tracker
#(
    parameter int MAX_SHIFT = lrbt_pkg::MAX_SHIFT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    lrbt_evt_if.sink                           evt,
    lrbt_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [lrbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrbt_pkg::DATA_W-1:0]        cfg_data
);

    lrbt_pkg::cmd_t cmd;
    lrbt_pkg::sts_t sts;

    lrbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lrbt_dp #(.MAX_SHIFT(MAX_SHIFT)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (evt.op),
        .connect_ok    (evt.connect_ok),
        .random_value  (evt.random_value),
        .now_us        (evt.now_us),
        .cmd           (cmd),
        .sts           (sts),
        .stop_timer    (rsp.stop_timer),
        .arm_timer     (rsp.arm_timer),
        .retry_delay   (rsp.retry_delay),
        .link_up       (rsp.link_up),
        .has_address   (rsp.has_address),
        .degraded      (rsp.degraded),
        .retries       (rsp.retries),
        .disconnects   (rsp.disconnects),
        .last_grant_us (rsp.last_grant_us)
    );

    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> !evt.ready)
        else $error("event taken while another is in flight");

    a_arm_implies_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.arm_timer) |-> rsp.stop_timer)
        else $error("timer armed without stop");

    a_idle_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.arm_timer) |-> (rsp.retry_delay == '0))
        else $error("nonzero delay without arm");

    a_addr_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.has_address) |-> rsp.link_up)
        else $error("address held with link down");

endmodule

[hdl/lrbt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbt_ctrl
// sequencer: accept, clamp, remainder iterations, jitter sum, result load
// ----------------------------------------------------------------------------
module lrbt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    output logic             evt_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  lrbt_pkg::sts_t   sts,
    output lrbt_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLAMP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [lrbt_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            vld_reg, vld_next;
    logic                            slot_free;

    assign slot_free = !vld_reg || rsp_ready;
    assign evt_ready = (state_reg == S_IDLE);
    assign rsp_valid = vld_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.sched ? S_CLAMP : S_DONE;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                cnt_next   = lrbt_pkg::DIV_CNT_W'(lrbt_pkg::DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.load_out)
        begin
            vld_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
        end
    end

endmodule

[hdl/lrbt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbt_dp
// link status state, config registers, backoff shift and clamp, iterative
// jitter remainder and result register
// ----------------------------------------------------------------------------
module lrbt_dp
#(
    parameter int MAX_SHIFT = lrbt_pkg::MAX_SHIFT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lrbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrbt_pkg::DATA_W-1:0]        cfg_data,
    input  logic [lrbt_pkg::OP_W-1:0]          op,
    input  logic                               connect_ok,
    input  logic [lrbt_pkg::DATA_W-1:0]        random_value,
    input  logic [lrbt_pkg::TIME_W-1:0]        now_us,
    input  lrbt_pkg::cmd_t                     cmd,
    output lrbt_pkg::sts_t                     sts,
    output logic                               stop_timer,
    output logic                               arm_timer,
    output logic [lrbt_pkg::DATA_W-1:0]        retry_delay,
    output logic                               link_up,
    output logic                               has_address,
    output logic                               degraded,
    output logic [lrbt_pkg::DATA_W-1:0]        retries,
    output logic [lrbt_pkg::DATA_W-1:0]        disconnects,
    output logic [lrbt_pkg::TIME_W-1:0]        last_grant_us
);

    localparam int DW   = lrbt_pkg::DATA_W;
    localparam int SH_W = $clog2(MAX_SHIFT + 1);
    localparam int D_W  = DW + MAX_SHIFT;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    logic [DW-1:0]  base_reg, max_reg;
    logic           link_reg, addr_reg, degr_reg;
    logic [DW-1:0]  retry_reg, disc_reg;
    logic [lrbt_pkg::TIME_W-1:0] grant_reg;

    logic           stop_reg, arm_reg;
    logic [SH_W-1:0] sh_reg;
    logic [DW-1:0]  num_reg, rem_reg, dvs_reg, dly_reg;

    logic           o_stop_reg, o_arm_reg, o_link_reg, o_addr_reg, o_degr_reg;
    logic [DW-1:0]  o_dly_reg, o_retry_reg, o_disc_reg;
    logic [lrbt_pkg::TIME_W-1:0] o_grant_reg;

    logic [DW-1:0]  cap;
    logic [DW-1:0]  count_base;
    logic           sched;
    logic [DW-1:0]  retry_next;
    logic [D_W-1:0] shifted;
    logic [DW-1:0]  clamped;
    logic [DW-1:0]  trial;
    logic [DW:0]    jit_sum;

    assign cap = (max_reg < base_reg) ? base_reg : max_reg;

    assign sched = (op == lrbt_pkg::OP_CONN_FAIL) || (op == lrbt_pkg::OP_DISCONN) ||
                   ((op == lrbt_pkg::OP_START) && !connect_ok);
    assign sts.sched = sched;

    assign count_base = (op == lrbt_pkg::OP_START) ? '0 : retry_reg;

    always_comb
    begin
        retry_next = retry_reg;
        if (sched)
        begin
            retry_next = (count_base == ALL_ONES) ? count_base : count_base + 1'b1;
        end
        else if ((op == lrbt_pkg::OP_START) || (op == lrbt_pkg::OP_GOT_ADDR))
        begin
            retry_next = '0;
        end
    end

    assign shifted = {{MAX_SHIFT{1'b0}}, base_reg} << sh_reg;
    assign clamped = (shifted > {{MAX_SHIFT{1'b0}}, cap}) ? cap : shifted[DW-1:0];

    // remainder stays below 2^30, so the top bit of rem is never lost
    assign trial   = {rem_reg[DW-2:0], num_reg[DW-1]};
    assign jit_sum = {1'b0, dly_reg} + {1'b0, rem_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= lrbt_pkg::BASE_DELAY_RST;
            max_reg   <= lrbt_pkg::MAX_DELAY_RST;
            link_reg  <= 1'b0;
            addr_reg  <= 1'b0;
            degr_reg  <= 1'b0;
            retry_reg <= '0;
            disc_reg  <= '0;
            grant_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lrbt_pkg::CFG_BASE_DELAY: base_reg <= cfg_data;
                    lrbt_pkg::CFG_MAX_DELAY:  max_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                retry_reg <= retry_next;
                case (op)
                    lrbt_pkg::OP_AP_JOIN:
                    begin
                        link_reg <= 1'b1;
                    end
                    lrbt_pkg::OP_DISCONN:
                    begin
                        link_reg <= 1'b0;
                        addr_reg <= 1'b0;
                        degr_reg <= 1'b1;
                        if (disc_reg != ALL_ONES)
                        begin
                            disc_reg <= disc_reg + 1'b1;
                        end
                    end
                    lrbt_pkg::OP_GOT_ADDR:
                    begin
                        link_reg  <= 1'b1;
                        addr_reg  <= 1'b1;
                        degr_reg  <= 1'b0;
                        grant_reg <= now_us;
                    end
                    lrbt_pkg::OP_LOST_ADDR:
                    begin
                        addr_reg <= 1'b0;
                        degr_reg <= 1'b1;
                    end
                    lrbt_pkg::OP_TIMEOUT:
                    begin
                        if (!addr_reg)
                        begin
                            degr_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stop_reg <= sched || (op == lrbt_pkg::OP_GOT_ADDR);
            arm_reg  <= sched;
            num_reg  <= random_value;
            sh_reg   <= (count_base > DW'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT)
                                                      : count_base[SH_W-1:0];
            dly_reg  <= '0;
        end
        if (cmd.clamp)
        begin
            dly_reg <= clamped;
            dvs_reg <= {2'b00, clamped[DW-1:2]} + 1'b1;
            rem_reg <= '0;
        end
        if (cmd.step)
        begin
            rem_reg <= (trial >= dvs_reg) ? trial - dvs_reg : trial;
            num_reg <= {num_reg[DW-2:0], 1'b0};
        end
        if (cmd.sum)
        begin
            dly_reg <= (jit_sum > {1'b0, cap}) ? cap : jit_sum[DW-1:0];
        end
        if (cmd.load_out)
        begin
            o_stop_reg  <= stop_reg;
            o_arm_reg   <= arm_reg;
            o_dly_reg   <= dly_reg;
            o_link_reg  <= link_reg;
            o_addr_reg  <= addr_reg;
            o_degr_reg  <= degr_reg;
            o_retry_reg <= retry_reg;
            o_disc_reg  <= disc_reg;
            o_grant_reg <= grant_reg;
        end
    end

    assign stop_timer    = o_stop_reg;
    assign arm_timer     = o_arm_reg;
    assign retry_delay   = o_dly_reg;
    assign link_up       = o_link_reg;
    assign has_address   = o_addr_reg;
    assign degraded      = o_degr_reg;
    assign retries       = o_retry_reg;
    assign disconnects   = o_disc_reg;
    assign last_grant_us = o_grant_reg;

endmodule
